// ===== hw/rtl/swm_pkg.sv =====
// Shared constants and types for the sliding-window median block.
package swm_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 31;

  localparam int unsigned CFG_W       = 7;
  localparam int unsigned COST_W      = 37;
  localparam int unsigned MEDIAN_W    = 31;
  localparam int unsigned OUT_TDATA_W = ((COST_W + MEDIAN_W + 7) / 8) * 8;

  // Row-wide command to every sort cell; at most one bit set.
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/swm_cell.sv =====
// One cell of the sorted row: holds one sample, inserts in order or shifts towards the head.
module swm_cell #(
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swm_pkg::cell_ctrl_t     ctrl_i,
  input  logic [SAMPLE_BITS-1:0]  key_i,
  input  logic [SAMPLE_BITS-1:0]  left_val_i,
  input  logic                    left_gt_i,
  input  logic                    left_vld_i,
  input  logic [SAMPLE_BITS-1:0]  right_val_i,
  input  logic                    right_vld_i,
  output logic [SAMPLE_BITS-1:0]  val_o,
  output logic                    gt_o,
  output logic                    vld_o
);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic                   vld_q, vld_d;
  logic                   take_key;

  assign gt_o  = vld_q & (val_q > key_i);
  // key lands in the first cell that is larger than it, or in the first empty cell
  assign take_key = ~left_gt_i & (gt_o | (~vld_q & left_vld_i));

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        val_d = left_val_i;
        vld_d = 1'b1;
      end else if (take_key) begin
        val_d = key_i;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

// ===== hw/rtl/swm_ring.sv =====
// Sample history memory: one write port, one registered read port.
module swm_ring #(
  parameter int unsigned DEPTH = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned WIDTH = swm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/sliding_window_median_cost.sv =====
// Top level of the sliding-window median and absolute-deviation cost block.
//
// Each input transaction stores its sample in the history memory. Once at least L samples
// (L = window length register, 0 read as 1, capped at MAX_WINDOW) are held since the last
// start-of-stream, the block rebuilds a sorted row of cells from the L newest samples, one
// memory read and one ordered insertion per cycle, then shifts all L values out through the
// head cell, summing deviations around the lower median, and then forms the result in a
// finish step. The input is not ready from a transaction that yields a result until that
// finish step ends; after an item that yields none, the block is ready again for the next
// sample. The single read port of the history memory and the one-value-per-cycle shift of
// the cell row set this pace. A finished result waits in an output register, so the next
// sample is taken while it is pending. The configuration port is always ready and must
// only be written while the block is idle.
module sliding_window_median_cost #(
  parameter int unsigned MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration: window length
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]              cfg_data_i,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample, zero pad
  input  logic [0:0]                             s_axis_tuser,  // start_of_stream
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [swm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata   // window_cost, window_median, zero pad
);

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;
  localparam int unsigned COST_W = swm_pkg::COST_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [swm_pkg::CFG_W-1:0] win_len_q;
  logic [CNT_W-1:0]         fill_q, fill_d, fill_base;
  logic [PTR_W-1:0]         ptr_q, ptr_d, wr_ptr;
  logic [CNT_W-1:0]         len_q, len_eff, med_idx;
  logic [PTR_W-1:0]         rd_addr_q;
  logic [CNT_W-1:0]         rd_cnt_q;
  logic                     ins_v_q;
  logic [CNT_W-1:0]         drn_q;
  logic [COST_W-1:0]        acc_q;
  logic [SAMPLE_BITS-1:0]   med_q;
  logic                     out_valid_q;
  logic [swm_pkg::OUT_TDATA_W-1:0] out_data_q;

  logic                     in_acc, cfg_acc, rd_en, has_result, out_load;
  logic [SAMPLE_BITS-1:0]   sample, rd_data, head;
  logic [COST_W-1:0]        cost;
  swm_pkg::cell_ctrl_t      cell_ctrl;

  logic [SAMPLE_BITS-1:0]   cell_val [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]    cell_gt;
  logic [MAX_WINDOW-1:0]    cell_vld;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];

  // effective window length
  always_comb begin
    if (win_len_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (CMP_W'(win_len_q) > CMP_W'(MAX_WINDOW)) begin
      len_eff = CNT_W'(MAX_WINDOW);
    end else begin
      len_eff = CNT_W'(win_len_q);
    end
  end

  assign wr_ptr    = s_axis_tuser[0] ? '0 : ptr_q;
  assign ptr_d     = (wr_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : wr_ptr + PTR_W'(1);
  assign fill_base = s_axis_tuser[0] ? '0 : fill_q;
  assign fill_d    = (fill_base < CNT_W'(MAX_WINDOW)) ? fill_base + CNT_W'(1) : fill_base;
  assign has_result = (fill_d >= len_eff);

  assign rd_en   = (state_q == ST_LOAD) && (rd_cnt_q != len_q);
  assign med_idx = (len_q - CNT_W'(1)) >> 1;
  assign head    = cell_val[0];

  // even windows carry one more sample above the median than below it
  assign cost     = acc_q - (len_q[0] ? '0 : COST_W'(med_q));
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign cell_ctrl.clear  = in_acc;
  assign cell_ctrl.insert = ins_v_q;
  assign cell_ctrl.shift  = (state_q == ST_DRAIN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && has_result) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (rd_cnt_q == len_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drn_q == len_q - CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= swm_pkg::CFG_W'(1);
      fill_q      <= '0;
      ptr_q       <= '0;
      len_q       <= CNT_W'(1);
      rd_addr_q   <= '0;
      rd_cnt_q    <= '0;
      ins_v_q     <= 1'b0;
      drn_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ins_v_q <= rd_en;
      if (cfg_acc) begin
        win_len_q <= cfg_data_i;
      end
      if (in_acc) begin
        fill_q    <= fill_d;
        ptr_q     <= ptr_d;
        len_q     <= len_eff;
        rd_addr_q <= wr_ptr;
        rd_cnt_q  <= '0;
        drn_q     <= '0;
      end
      if (rd_en) begin
        rd_addr_q <= (rd_addr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_addr_q - PTR_W'(1);
        rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
      end
      if (state_q == ST_DRAIN) begin
        drn_q <= drn_q + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // accumulator works modulo 2^COST_W; samples below the median are taken off
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q <= '0;
    end else if (state_q == ST_DRAIN) begin
      if (drn_q < med_idx) begin
        acc_q <= acc_q - COST_W'(head);
      end else if (drn_q > med_idx) begin
        acc_q <= acc_q + COST_W'(head);
      end else begin
        med_q <= head;
      end
    end
    if (out_load) begin
      out_data_q <= swm_pkg::OUT_TDATA_W'({swm_pkg::MEDIAN_W'(med_q), cost});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  swm_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_BITS),
    .AW    (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (wr_ptr),
    .wr_data_i (sample),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_data)
  );

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] left_val, right_val;
    logic                   left_gt, left_vld, right_vld;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
      assign left_vld = 1'b1;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
      assign left_vld = cell_vld[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
      assign right_vld = cell_vld[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .key_i       (rd_data),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .left_vld_i  (left_vld),
      .right_val_i (right_val),
      .right_vld_i (right_vld),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i]),
      .vld_o       (cell_vld[i])
    );
  end

  // row holds exactly the window once loading ends
  a_row_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && rd_cnt_q == len_q) |=> ($countones(cell_vld) == int'(len_q)))
    else $error("sorted row does not hold the window after loading");

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (rd_cnt_q <= len_q))
    else $error("history reads overran the window");

  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (drn_q < len_q))
    else $error("drain counter beyond window");

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_WINDOW))
    else $error("fill count above maximum window");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the finish step");

endmodule

// ===== tb/sliding_window_median_cost_tb.sv =====
// Self-checking testbench for the sliding-window median and deviation cost block.
module sliding_window_median_cost_tb;

  localparam int unsigned IN_TDATA_W    = ((swm_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
  // wait for the longest result, at L = MAX_WINDOW, plus margin
  localparam int unsigned SETTLE_CYCLES = 2 * swm_pkg::MAX_WINDOW_DEF + 3 + 16;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef bit [swm_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
  typedef bit [swm_pkg::COST_W-1:0]          cost_t;
  typedef bit [swm_pkg::CFG_W-1:0]           win_len_t;

  typedef struct packed {
    cost_t   cost;
    sample_t median;
  } window_result_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  localparam sample_t SAMPLE_MAX = '1;

  // Tracks the sample history and predicts median and cost for each sample taken.
  class median_cost_scoreboard;
    sample_t        history[swm_pkg::MAX_WINDOW_DEF];
    int unsigned    fill;
    int unsigned    next_slot;
    win_len_t       len_reg;
    window_result_t expected_q[$];
    int unsigned    results_seen;
    int unsigned    mismatch_count;

    function new();
      fill           = 0;
      next_slot      = 0;
      len_reg        = 1;
      results_seen   = 0;
      mismatch_count = 0;
    endfunction

    function void set_window_len(win_len_t v);
      len_reg = v;
    endfunction

    function void note_sample(sample_t s, bit sos);
      sample_t         win[swm_pkg::MAX_WINDOW_DEF];
      sample_t         v;
      sample_t         med;
      int unsigned     len;
      int unsigned     i;
      int              j;
      longint unsigned acc;
      window_result_t  r;
      if (sos) begin
        fill      = 0;
        next_slot = 0;
      end
      history[next_slot] = s;
      next_slot = (next_slot + 1) % swm_pkg::MAX_WINDOW_DEF;
      if (fill < swm_pkg::MAX_WINDOW_DEF) fill++;
      // zero reads as one, anything past the store size is capped
      if (len_reg == 0) len = 1;
      else if (len_reg > swm_pkg::MAX_WINDOW_DEF) len = swm_pkg::MAX_WINDOW_DEF;
      else len = len_reg;
      if (fill < len) return;
      for (i = 0; i < len; i++) begin
        v = history[(next_slot + 2 * swm_pkg::MAX_WINDOW_DEF - 1 - i) %
                    swm_pkg::MAX_WINDOW_DEF];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      med = win[(len - 1) / 2];
      acc = 0;
      for (i = 0; i < len; i++) begin
        if (win[i] >= med) acc += win[i] - med;
        else acc += med - win[i];
      end
      r.cost   = acc[swm_pkg::COST_W-1:0];
      r.median = med;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      if (mismatch_count < MAX_REPORTS) $display("MISMATCH: %s", what);
      mismatch_count++;
    endtask

    task check_result(bit [swm_pkg::OUT_TDATA_W-1:0] tdata);
      cost_t          got_cost;
      sample_t        got_med;
      window_result_t want;
      got_cost = tdata[swm_pkg::COST_W-1:0];
      got_med  = tdata[swm_pkg::COST_W +: swm_pkg::MEDIAN_W];
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d unexpected: cost %0d median %0d",
                         results_seen, got_cost, got_med));
        return;
      end
      want = expected_q.pop_front();
      if (got_cost != want.cost)
        report($sformatf("result %0d cost %0d, want %0d", results_seen, got_cost, want.cost));
      if (got_med != want.median)
        report($sformatf("result %0d median %0d, want %0d",
                         results_seen, got_med, want.median));
    endtask
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [swm_pkg::CFG_W-1:0]       cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [IN_TDATA_W-1:0]           s_axis_tdata;   // sample, zero pad
  logic [0:0]                      s_axis_tuser;   // start_of_stream
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [swm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // window_cost, window_median, zero pad

  median_cost_scoreboard sb = new();

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_req;
  int unsigned samples_sent;
  int unsigned settings_written;
  int unsigned quiet_cycles;

  sliding_window_median_cost u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: checks each transaction, then picks next tready
  initial begin
    int unsigned hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: too long without any transaction ends the run
  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
             quiet_cycles, sb.expected_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return sample_t'($urandom());
      4, 5, 6:    return sample_t'($urandom_range(15));
      7:          return $urandom_range(1) ? SAMPLE_MAX : sample_t'(0);
      default:    return SAMPLE_MAX - sample_t'($urandom_range(255));
    endcase
  endfunction

  task set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      IDLE_SENDER: begin
        src_idle_pct  = 61;
        snk_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        src_idle_pct  = 0;
        snk_stall_pct = 61;
      end
      default: begin
        src_idle_pct  = 38;
        snk_stall_pct = 38;
      end
    endcase
  endtask

  // Entered just after a rising edge; returns in the step of the transaction.
  task send_sample(sample_t s, bit sos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(s);
    s_axis_tuser  <= sos;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s, sos);
    samples_sent++;
  endtask

  // Drop tvalid, wait for every expected result, then let the block go quiet.
  task settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_window_len(win_len_t v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_window_len(v);
    settings_written++;
  endtask

  task run_random(win_len_t len_val, idle_mode_e mode, int unsigned n, bit squeeze);
    int unsigned k;
    settle();
    write_window_len(len_val);
    set_idle_mode(mode);
    if (squeeze) begin
      src_idle_pct = 0;
      hold_req     = HOLD_CYCLES;
    end
    for (k = 0; k < n; k++) send_sample(random_sample(), $urandom_range(79) == 0);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = '0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    hold_req         = 0;
    samples_sent     = 0;
    settings_written = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length of one: every sample is its own median
    send_sample(0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(31'h5555_5555, 1'b1);
    send_sample(31'h2AAA_AAAA, 1'b0);
    // zero length reads as one
    settle();
    write_window_len(0);
    send_sample(7, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    // length three, with restarts part way through a window
    settle();
    write_window_len(3);
    send_sample(0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(5, 1'b0);
    send_sample(9, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b0);
    // grow mid-stream: first sample short of a window, second fills it
    settle();
    write_window_len(5);
    send_sample(3, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    // shrink mid-stream
    settle();
    write_window_len(2);
    send_sample(1, 1'b0);

    run_random(4,   IDLE_NONE,     150, 1'b0);
    run_random(1,   IDLE_SENDER,   100, 1'b0);
    run_random(64,  IDLE_RECEIVER, 150, 1'b0);
    run_random(127, IDLE_BOTH,     120, 1'b0);
    run_random(17,  IDLE_NONE,     150, 1'b1);
    run_random(0,   IDLE_BOTH,     100, 1'b0);
    run_random(2,   IDLE_RECEIVER, 150, 1'b0);
    run_random(win_len_t'($urandom_range(1, swm_pkg::MAX_WINDOW_DEF)), IDLE_SENDER, 150, 1'b0);
    run_random(100, IDLE_NONE,     100, 1'b0);
    run_random(5,   IDLE_BOTH,     150, 1'b0);

    settle();
    $display("Run covered %0d samples, %0d results, %0d window-length writes,",
             samples_sent, sb.results_seen, settings_written);
    $display("from zero through beyond the store size, under mixed idling and back-pressure.");
    if (sb.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
